### rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, character codes and helper functions of the postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

    // character codes
    localparam logic [7:0] C_END   = 8'h00;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_SLASH = 8'h2F;

    // precedence levels
    localparam logic [1:0] P_NONE = 2'd0;
    localparam logic [1:0] P_ADD  = 2'd1;
    localparam logic [1:0] P_MUL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_LETTER,
        CLS_LPAR,
        CLS_RPAR,
        CLS_OP
    } t_sym_class;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_stack_cmd;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       fresh;
        logic [7:0] top;
    } t_stack_stat;

    typedef struct packed {
        logic       emit;
        logic       finish;
        logic [7:0] sym;
        logic       ovf;
    } t_emit_cmd;

    typedef struct packed {
        logic room;
    } t_emit_stat;

    function automatic logic [1:0] f_prec(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            C_STAR, C_SLASH: p = P_MUL;
            C_PLUS, C_MINUS: p = P_ADD;
            default:         p = P_NONE;
        endcase
        return p;
    endfunction

    function automatic t_sym_class f_classify(input logic [7:0] c);
        t_sym_class k;
        if (c == C_END) begin
            k = CLS_END;
        end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            k = CLS_LETTER;
        end else if (c == C_LPAR) begin
            k = CLS_LPAR;
        end else if (c == C_RPAR) begin
            k = CLS_RPAR;
        end else begin
            k = CLS_OP;
        end
        return k;
    endfunction

endpackage

### rtl/core/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if
// input channel: one expression character per item
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

### rtl/core/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if
// result channel: postfix characters and expression terminators
// ----------------------------------------------------------------------------
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       run_last;
    logic       overflow;

    modport source (output valid, output out_symbol, output run_last, output overflow,
                    input ready);
    modport sink   (input valid, input out_symbol, input run_last, input overflow,
                    output ready);
endinterface

### rtl/core/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// operator stack in a memory with registered top-of-stack read
// ----------------------------------------------------------------------------
module itp_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  itp_pkg::t_stack_cmd    i_cmd,
    output itp_pkg::t_stack_stat   o_stat
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]    r_mem [STACK_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_rd_data;
    logic          r_fresh;
    logic [AW-1:0] w_rd_addr;
    logic          w_full;
    logic          w_empty;
    logic          w_push;

    assign w_full    = (r_count == CW'(STACK_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_push    = i_cmd.push && !w_full;
    assign w_rd_addr = w_empty ? '0 : AW'(r_count - CW'(1));

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop && !w_empty) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fresh <= 1'b0;
        end else begin
            r_count <= n_count;
            // read data is only trusted once the depth has held still
            r_fresh <= (n_count == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[AW'(r_count)] <= i_cmd.data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;
    assign o_stat.fresh = r_fresh;
    assign o_stat.top   = r_rd_data;

endmodule

### rtl/core/itp_emit.sv
// ----------------------------------------------------------------------------
// itp_emit
// result holding stage and output register; marks the last result of an item
// ----------------------------------------------------------------------------
module itp_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_emit_cmd   i_cmd,
    output itp_pkg::t_emit_stat  o_stat,
    itp_out_if.source            o_out
);
    logic       r_pend_v;
    logic [7:0] r_pend_sym;
    logic       r_pend_ovf;
    logic       r_out_v;
    logic [7:0] r_out_sym;
    logic       r_out_last;
    logic       r_out_ovf;
    logic       w_out_free;
    logic       w_move;

    assign w_out_free  = !r_out_v || o_out.ready;
    assign o_stat.room = !r_pend_v || w_out_free;
    // held result leaves once the next one arrives or the item is finished
    assign w_move      = r_pend_v && (i_cmd.emit || i_cmd.finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend_sym <= i_cmd.sym;
            r_pend_ovf <= i_cmd.ovf;
        end
        if (w_move) begin
            r_out_sym  <= r_pend_sym;
            r_out_ovf  <= r_pend_ovf;
            r_out_last <= i_cmd.finish;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.out_symbol = r_out_sym;
    assign o_out.run_last   = r_out_last;
    assign o_out.overflow   = r_out_ovf;

endmodule

### rtl/core/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard conversion of an infix character stream to postfix order
// ----------------------------------------------------------------------------
// One character is taken per item and the block then works on it alone,
// raising ready again once its results are all handed to the output stage.
// A letter is accepted, processed and then released. Each operator
// popped from the stack is followed by a wait for a settled top, because
// the stack lives in a memory whose top is read through a registered port
// and a fresh top is only seen once the depth has held still; no such wait
// follows a pop that leaves the stack empty. A stalled output holds the
// sequencer. The stack needs no clearing pass after reset: only entries
// below the depth are read. The terminator always leaves the stack empty.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itp_in_if.sink     i_in,
    itp_out_if.source  o_out
);
    itp_pkg::t_state       r_state;
    itp_pkg::t_state       n_state;
    logic [7:0]            r_sym;
    logic                  r_ovf;
    logic                  w_ovf_set;
    logic                  w_ovf_clr;
    itp_pkg::t_sym_class   w_cls;
    itp_pkg::t_stack_cmd   w_stk_cmd;
    itp_pkg::t_stack_stat  w_stk_stat;
    itp_pkg::t_emit_cmd    w_emit_cmd;
    itp_pkg::t_emit_stat   w_emit_stat;
    logic                  w_accept;
    logic                  w_need_top;
    logic                  w_wait;
    logic                  w_pop_cond;
    logic                  w_needs_room;
    logic                  w_run_done;

    // decode of the held character
    assign w_cls    = itp_pkg::f_classify(r_sym);
    assign w_accept = i_in.valid && i_in.ready;

    // letters and '(' never look at the stack top
    assign w_need_top = !w_stk_stat.empty
                        && (w_cls != itp_pkg::CLS_LETTER) && (w_cls != itp_pkg::CLS_LPAR);
    assign w_wait     = w_need_top && !w_stk_stat.fresh;

    // pop condition for the current step
    always_comb begin
        w_pop_cond = 1'b0;
        if (!w_stk_stat.empty) begin
            case (w_cls)
                itp_pkg::CLS_END:  w_pop_cond = 1'b1;
                itp_pkg::CLS_RPAR: w_pop_cond = (w_stk_stat.top != itp_pkg::C_LPAR);
                itp_pkg::CLS_OP:   w_pop_cond = (itp_pkg::f_prec(w_stk_stat.top)
                                                 >= itp_pkg::f_prec(r_sym));
                default:           w_pop_cond = 1'b0;
            endcase
        end
    end

    // terminator and letters produce a result on their final step
    assign w_needs_room = (w_cls == itp_pkg::CLS_END) || (w_cls == itp_pkg::CLS_LETTER);
    assign w_run_done   = !w_wait && !w_pop_cond && (w_emit_stat.room || !w_needs_room);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = itp_pkg::ST_RUN;
                end
            end
            itp_pkg::ST_RUN: begin
                if (w_run_done) begin
                    n_state = itp_pkg::ST_FIN;
                end
            end
            itp_pkg::ST_FIN: begin
                if (w_emit_stat.room) begin
                    n_state = itp_pkg::ST_IDLE;
                end
            end
            default: n_state = itp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready        = 1'b0;
        w_stk_cmd.push    = 1'b0;
        w_stk_cmd.pop     = 1'b0;
        w_stk_cmd.data    = r_sym;
        w_emit_cmd.emit   = 1'b0;
        w_emit_cmd.finish = 1'b0;
        w_emit_cmd.sym    = w_stk_stat.top;
        w_emit_cmd.ovf    = 1'b0;
        w_ovf_set         = 1'b0;
        w_ovf_clr         = 1'b0;
        case (r_state)
            itp_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            itp_pkg::ST_RUN: begin
                if (!w_wait) begin
                    if (w_pop_cond) begin
                        // pop one operator and pass it on
                        if (w_emit_stat.room) begin
                            w_stk_cmd.pop   = 1'b1;
                            w_emit_cmd.emit = 1'b1;
                        end
                    end else begin
                        case (w_cls)
                            itp_pkg::CLS_END: begin
                                if (w_emit_stat.room) begin
                                    w_emit_cmd.emit = 1'b1;
                                    w_emit_cmd.sym  = itp_pkg::C_END;
                                    w_emit_cmd.ovf  = r_ovf;
                                    w_ovf_clr       = 1'b1;
                                end
                            end
                            itp_pkg::CLS_LETTER: begin
                                if (w_emit_stat.room) begin
                                    w_emit_cmd.emit = 1'b1;
                                    w_emit_cmd.sym  = r_sym;
                                end
                            end
                            itp_pkg::CLS_RPAR: begin
                                // drop the matching '(' if there is one
                                w_stk_cmd.pop = !w_stk_stat.empty;
                            end
                            default: begin
                                // '(' and operators are pushed, lost when full
                                w_stk_cmd.push = 1'b1;
                                w_ovf_set      = w_stk_stat.full;
                            end
                        endcase
                    end
                end
            end
            itp_pkg::ST_FIN: begin
                w_emit_cmd.finish = w_emit_stat.room;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::ST_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ovf_set) begin
                r_ovf <= 1'b1;
            end else if (w_ovf_clr) begin
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym <= i_in.symbol;
        end
    end

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_stk_cmd),
        .o_stat  (w_stk_stat)
    );

    itp_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_emit_cmd),
        .o_stat  (w_emit_stat),
        .o_out   (o_out)
    );

    // an accepted item is always worked on in the next cycle
    a_accept_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == itp_pkg::ST_RUN))
        else $error("accepted item not taken into processing");

    // the stack is never popped when empty
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stk_cmd.pop |-> !w_stk_stat.empty)
        else $error("pop issued on empty stack");

    // a popped operator is only taken from a settled top read
    a_fresh_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stk_cmd.pop && w_emit_cmd.emit) |-> w_stk_stat.fresh)
        else $error("stale stack top emitted");

    // results are only produced when the holding stage has room
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_cmd.emit || w_emit_cmd.finish) |-> w_emit_stat.room)
        else $error("result issued without room");

    // overflow is only flagged on the terminator, which ends its item
    a_ovf_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (o_out.out_symbol == itp_pkg::C_END)
                                            && o_out.run_last)
        else $error("overflow flagged outside terminator");

endmodule

### test/infix_to_postfix_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb
// self-checking bench for the shunting-yard postfix converter
// ----------------------------------------------------------------------------
// Characters are queued by the stimulus process and handed to the block by a
// clocked driver with random gaps. A clocked monitor takes the results under
// random back-pressure and checks each one against the oldest entry of the
// postfix queue, which an in-bench copy of the operator stack fills at every
// accepted item.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;

    localparam int          STACK_DEPTH  = 32;
    localparam int          N_RANDOM     = 450;
    localparam int          SETTLE_CYC   = 100;
    localparam int          LIMIT_CYCLES = 2000000;
    localparam logic [7:0]  OPS [4]      = '{itp_pkg::C_PLUS, itp_pkg::C_MINUS,
                                             itp_pkg::C_STAR, itp_pkg::C_SLASH};

    typedef struct {
        logic [7:0] sym;
        logic       last;
        logic       ovf;
    } t_postfix;

    typedef struct {
        logic [7:0] sym;
        bit         hold;
    } t_feed;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_to_postfix_converter_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // characters waiting for the driver, and results waiting for the block
    t_feed      char_feed [$];
    t_postfix   postfix_q [$];
    bit         drain_next;

    // in-bench operator stack
    logic [7:0] op_stack [STACK_DEPTH];
    int         op_depth;
    logic       ovf_flag;

    int         err_cnt;
    int         items_in;
    int         results_chk;
    int         term_cnt;
    int         ovf_cnt;
    int         cycle_cnt;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int op_rank(input logic [7:0] c);
        if (c == itp_pkg::C_STAR || c == itp_pkg::C_SLASH) return 2;
        if (c == itp_pkg::C_PLUS || c == itp_pkg::C_MINUS) return 1;
        return 0;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void op_push(input logic [7:0] c);
        if (op_depth >= STACK_DEPTH) begin
            ovf_flag = 1'b1;
        end else begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    function automatic void convert_symbol(input logic [7:0] c);
        t_postfix res [$];
        int       rank;
        if (c == itp_pkg::C_END) begin
            while (op_depth > 0) begin
                op_depth--;
                res.push_back('{op_stack[op_depth], 1'b0, 1'b0});
            end
            res.push_back('{itp_pkg::C_END, 1'b0, ovf_flag});
            ovf_flag = 1'b0;
        end else if (is_alpha(c)) begin
            res.push_back('{c, 1'b0, 1'b0});
        end else if (c == itp_pkg::C_LPAR) begin
            op_push(c);
        end else if (c == itp_pkg::C_RPAR) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != itp_pkg::C_LPAR) begin
                op_depth--;
                res.push_back('{op_stack[op_depth], 1'b0, 1'b0});
            end
            // matching '(' is dropped; unmatched ')' just empties the stack
            if (op_depth > 0) op_depth--;
        end else begin
            rank = op_rank(c);
            while (op_depth > 0 && op_rank(op_stack[op_depth - 1]) >= rank) begin
                op_depth--;
                res.push_back('{op_stack[op_depth], 1'b0, 1'b0});
            end
            op_push(c);
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[k]) postfix_q.push_back(res[k]);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void feed_byte(input logic [7:0] c);
        char_feed.push_back('{c, drain_next});
        drain_next = 1'b0;
    endfunction

    function automatic void feed_text(input string s);
        for (int k = 0; k < s.len(); k++) feed_byte(s[k]);
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic void feed_operand(input int level);
        if (level < 4 && $urandom_range(0, 3) == 0) begin
            feed_byte(itp_pkg::C_LPAR);
            feed_expr(level + 1);
            feed_byte(itp_pkg::C_RPAR);
        end else begin
            feed_byte(any_letter());
        end
    endfunction

    function automatic void feed_expr(input int level);
        int terms;
        terms = $urandom_range(1, 4);
        feed_operand(level);
        for (int k = 1; k < terms; k++) begin
            feed_byte(OPS[$urandom_range(0, 3)]);
            feed_operand(level);
        end
    endfunction

    // long run of '(' that walks off the top of the stack when n is large
    function automatic void feed_deep(input int n);
        for (int k = 0; k < n; k++) feed_byte(itp_pkg::C_LPAR);
        feed_byte(any_letter());
        feed_byte(OPS[$urandom_range(0, 3)]);
        feed_byte(any_letter());
        for (int k = $urandom_range(0, n); k > 0; k--) feed_byte(itp_pkg::C_RPAR);
        feed_byte(itp_pkg::C_END);
    endfunction

    function automatic void feed_junk();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 4))
                0: feed_byte(8'($urandom_range(0, 255)));
                1: feed_byte(any_letter());
                2: feed_byte(OPS[$urandom_range(0, 3)]);
                3: feed_byte($urandom_range(0, 1) ? itp_pkg::C_LPAR : itp_pkg::C_RPAR);
                default: feed_byte(8'h30 + 8'($urandom_range(0, 9)));
            endcase
        end
    endfunction

    function automatic void note_error(input string msg);
        if (err_cnt < 10) $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endfunction

    // ------------------------------------------------------------------------
    // driver: takes characters from the feed queue, random gap after each
    // ------------------------------------------------------------------------
    int tx_gap;
    bit tx_calm;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.symbol <= itp_pkg::C_END;
            tx_gap       = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                convert_symbol(in_ch.symbol);
                items_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end else if (char_feed.size() > 0 &&
                             !(char_feed[0].hold && postfix_q.size() != 0)) begin
                    in_ch.valid  <= 1'b1;
                    in_ch.symbol <= char_feed[0].sym;
                    void'(char_feed.pop_front());
                    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 11);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random stall after each result, checks against postfix queue
    // ------------------------------------------------------------------------
    int       rx_stall;
    bit       rx_calm;
    t_postfix want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall     = $urandom_range(0, 11);
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_chk++;
                if (out_ch.out_symbol === itp_pkg::C_END) term_cnt++;
                if (out_ch.overflow === 1'b1) ovf_cnt++;
                if (postfix_q.size() == 0) begin
                    note_error($sformatf("unexpected result sym=%02h last=%b ovf=%b",
                                         out_ch.out_symbol, out_ch.run_last,
                                         out_ch.overflow));
                end else begin
                    want = postfix_q.pop_front();
                    if (out_ch.out_symbol !== want.sym || out_ch.run_last !== want.last ||
                        out_ch.overflow !== want.ovf) begin
                        note_error($sformatf({"sym exp %02h got %02h, last exp %b got %b, ",
                                              "ovf exp %b got %b"},
                                             want.sym, out_ch.out_symbol,
                                             want.last, out_ch.run_last,
                                             want.ovf, out_ch.overflow));
                    end
                end
                if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n_first;
        int pick;
        bit mid_hold;
        i_rst_n      = 1'b0;
        op_depth     = 0;
        ovf_flag     = 1'b0;
        drain_next   = 1'b0;
        mid_hold     = 1'b0;

        // directed: nested expression, letter extremes, unmatched ')',
        // digit and unknown bytes popping '(', terminator on an empty stack
        feed_text("A+B*(C-Z)/a");
        feed_byte(itp_pkg::C_END);
        feed_text("(z-7)");
        feed_byte(8'hFF);
        feed_byte(itp_pkg::C_STAR);
        feed_byte(8'h01);
        feed_byte(itp_pkg::C_RPAR);
        feed_byte(itp_pkg::C_END);
        feed_byte(itp_pkg::C_END);
        n_first = char_feed.size();

        // first random item waits for the block to drain completely
        drain_next = 1'b1;
        feed_deep(36);
        while (char_feed.size() < n_first + N_RANDOM) begin
            if (!mid_hold && char_feed.size() > n_first + N_RANDOM / 2) begin
                drain_next = 1'b1;
                mid_hold   = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                feed_expr(0);
                feed_byte(itp_pkg::C_END);
            end else if (pick < 65) begin
                feed_deep($urandom_range(26, 40));
            end else begin
                feed_junk();
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_feed.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (postfix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (postfix_q.size() != 0) begin
            note_error($sformatf("%0d results never arrived", postfix_q.size()));
        end
        $display("covered %0d characters, %0d postfix results checked", items_in,
                 results_chk);
        $display("expressions closed: %0d, stack overflows reported: %0d, mismatches: %0d",
                 term_cnt, ovf_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
